>>> hw/rtl/dotn_pkg.sv
`timescale 1ns / 1ps
package dotn_pkg;

   // followers are unsigned Q1.23
   localparam int FOLLOWER_BITS = 24;
   localparam int PEAK_BITS = 16;
   localparam int COEF_BITS = 16;
   localparam int LEVEL_BITS = 15;
   localparam int NOTE_BITS = 7;

   localparam logic [FOLLOWER_BITS-1:0] ONE_Q23 = 24'h800000;
   localparam logic [LEVEL_BITS-1:0] ENV_MAX = 15'h7fff;
   localparam logic [NOTE_BITS-1:0] VEL_MAX = 7'd127;

   typedef logic [FOLLOWER_BITS-1:0] follower_type;
   typedef logic [PEAK_BITS-1:0] peak_type;
   typedef logic [COEF_BITS-1:0] coef_type;
   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [NOTE_BITS-1:0] note_type;

   typedef logic [3:0] csr_addr_type;
   typedef logic [31:0] csr_data_type;
   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_RELEASE_COEF = 2'd0;
   localparam reg_index_type REG_ATTACK_COEF = 2'd1;
   localparam reg_index_type REG_ONSET_THRESHOLD = 2'd2;
   localparam reg_index_type REG_NOTE_NUMBER = 2'd3;

   localparam coef_type RESET_RELEASE_COEF = 16'd65365;
   localparam coef_type RESET_ATTACK_COEF = 16'd65026;
   localparam level_type RESET_ONSET_THRESHOLD = 15'd6554;
   localparam note_type RESET_NOTE_NUMBER = 7'd38;

endpackage

>>> hw/rtl/dotn_req_if.sv
`timescale 1ns / 1ps
interface dotn_req_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int POSITION_BITS = 12
);
   logic valid;
   logic ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;
   logic [POSITION_BITS-1:0] frame_position;

   modport source (output valid, output sample_value, output frame_position, input ready);
   modport sink (input valid, input sample_value, input frame_position, output ready);
endinterface

>>> hw/rtl/dotn_rsp_if.sv
`timescale 1ns / 1ps
interface dotn_rsp_if #(
   parameter int POSITION_BITS = 12
);
   logic valid;
   logic ready;
   dotn_pkg::level_type envelope_level;
   logic note_on_valid;
   dotn_pkg::note_type note_out;
   dotn_pkg::note_type velocity;
   logic [POSITION_BITS-1:0] event_time;

   modport source (
      output valid, output envelope_level, output note_on_valid, output note_out,
      output velocity, output event_time, input ready
   );
   modport sink (
      input valid, input envelope_level, input note_on_valid, input note_out,
      input velocity, input event_time, output ready
   );
endinterface

>>> hw/rtl/drum_onset_to_note_on_unit.sv
`timescale 1ns / 1ps
// Transient onset detector: turns a stream of audio samples into drum note-on events.
// req carries one signed sample and its frame position per transaction; rsp returns
// exactly one transaction per sample: the Q15 envelope and, when the envelope drops
// back to the threshold, a note-on with note, velocity and frame position.
// Registers (release pole, attack pole, threshold, note) sit on an APB-style port at
// byte addresses 0, 4, 8 and 12; a write made mid-sample is not held back to the next one.
// Each sample passes through the states REL_MUL, REL_ADD, ATT_MUL, ATT_ADD and FIN from
// acceptance to a loaded result: the release and the attack follower updates both go
// through the one shared 25x17 multiplier and the one shared mix adder (a multiply state
// and an add state each), and FIN does the envelope, window and peak logic. req.ready is
// high only in IDLE, so a new sample is taken only after the last one is finished.
// The result sits in an output register; if the receiver stalls, the next sample is
// still accepted and its computation runs, then waits in the last step until the
// register frees.
// Synchronous reset clears the followers, the window flag and the peak, and loads
// the register defaults.
module drum_onset_to_note_on_unit #(
   parameter int SAMPLE_BITS = 16,
   parameter int POSITION_BITS = 12
) (
   input logic clock,
   input logic reset,
   dotn_req_if.sink req,
   dotn_rsp_if.source rsp,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input dotn_pkg::csr_addr_type paddr,
   input dotn_pkg::csr_data_type pwdata,
   output dotn_pkg::csr_data_type prdata,
   output logic pready
);
   import dotn_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_REL_MUL = 3'd1;
   localparam logic [2:0] S_REL_ADD = 3'd2;
   localparam logic [2:0] S_ATT_MUL = 3'd3;
   localparam logic [2:0] S_ATT_ADD = 3'd4;
   localparam logic [2:0] S_FIN = 3'd5;

   localparam int PROD_BITS = FOLLOWER_BITS + COEF_BITS + 2;

   logic [2:0] state_ff, state_in;
   coef_type release_coef_ff, release_coef_in;
   coef_type attack_coef_ff, attack_coef_in;
   level_type threshold_ff, threshold_in;
   note_type note_number_ff, note_number_in;
   follower_type rel_ff, rel_in;
   follower_type att_ff, att_in;
   logic open_ff, open_in;
   peak_type peak_ff, peak_in;
   follower_type ax_ff, ax_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic rsp_valid_ff, rsp_valid_in;
   level_type env_out_ff, env_out_in;
   logic fire_out_ff, fire_out_in;
   note_type note_out_ff, note_out_in;
   note_type vel_out_ff, vel_out_in;
   logic [POSITION_BITS-1:0] time_out_ff, time_out_in;

   logic [SAMPLE_BITS-1:0] sample_bits;
   logic [SAMPLE_BITS-1:0] mag;
   logic req_take;
   logic csr_write;
   reg_index_type csr_index;

   // shared multiply-mix unit
   follower_type mul_a, mul_b, mix_drive;
   coef_type mul_coef;
   logic signed [FOLLOWER_BITS:0] mul_diff;
   logic signed [PROD_BITS-1:0] mix_sum;
   logic [FOLLOWER_BITS+1:0] mix_q;
   follower_type mix_out;

   // envelope and event logic
   logic [FOLLOWER_BITS-1:0] env_diff;
   logic [PEAK_BITS-1:0] env_wide;
   level_type env;
   peak_type ax15;
   logic open_now;
   logic fire;
   logic [PEAK_BITS+NOTE_BITS-1:0] vel_prod;
   logic [7:0] vel_raw;
   note_type vel;
   logic out_free;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      case (csr_index)
         REG_RELEASE_COEF: prdata = csr_data_type'(release_coef_ff);
         REG_ATTACK_COEF: prdata = csr_data_type'(attack_coef_ff);
         REG_ONSET_THRESHOLD: prdata = csr_data_type'(threshold_ff);
         REG_NOTE_NUMBER: prdata = csr_data_type'(note_number_ff);
         default: prdata = '0;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign req_take = req.valid && (state_ff == S_IDLE);

   assign sample_bits = req.sample_value;
   assign mag = sample_bits[SAMPLE_BITS-1] ? (~sample_bits + 1'b1) : sample_bits;

   // operand select: release pass mixes ax into rel, attack pass mixes rel into att
   always_comb begin
      if (state_ff == S_REL_MUL || state_ff == S_REL_ADD) begin
         mul_a = rel_ff;
         mul_b = ax_ff;
         mul_coef = release_coef_ff;
      end else begin
         mul_a = att_ff;
         mul_b = rel_ff;
         mul_coef = attack_coef_ff;
      end
   end

   assign mix_drive = mul_b;
   // prev*c + drive*(1-c) written as drive + (prev-drive)*c
   assign mul_diff = $signed({1'b0, mul_a}) - $signed({1'b0, mul_b});
   assign prod_in = PROD_BITS'(mul_diff * $signed({1'b0, mul_coef}));
   assign mix_sum = $signed({2'b00, mix_drive, {COEF_BITS{1'b0}}}) + prod_ff
                  + $signed(PROD_BITS'(32768));
   assign mix_q = mix_sum[PROD_BITS-1:COEF_BITS];
   assign mix_out = (mix_q > (FOLLOWER_BITS+2)'(ONE_Q23)) ? ONE_Q23 : mix_q[FOLLOWER_BITS-1:0];

   assign env_diff = rel_ff - att_ff;
   assign env_wide = env_diff[FOLLOWER_BITS-1:8];
   always_comb begin
      if (rel_ff > att_ff) begin
         env = (env_wide > PEAK_BITS'(ENV_MAX)) ? ENV_MAX : env_wide[LEVEL_BITS-1:0];
      end else begin
         env = '0;
      end
   end

   assign ax15 = ax_ff[FOLLOWER_BITS-1:8];
   assign open_now = env > threshold_ff;
   assign fire = !open_now && open_ff;
   assign vel_prod = {peak_ff, {NOTE_BITS{1'b0}}} - (PEAK_BITS+NOTE_BITS)'(peak_ff);
   assign vel_raw = vel_prod[PEAK_BITS+NOTE_BITS-1:15];
   assign vel = (vel_raw > 8'(VEL_MAX)) ? VEL_MAX : vel_raw[NOTE_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      release_coef_in = release_coef_ff;
      attack_coef_in = attack_coef_ff;
      threshold_in = threshold_ff;
      note_number_in = note_number_ff;
      rel_in = rel_ff;
      att_in = att_ff;
      open_in = open_ff;
      peak_in = peak_ff;
      ax_in = ax_ff;
      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      env_out_in = env_out_ff;
      fire_out_in = fire_out_ff;
      note_out_in = note_out_ff;
      vel_out_in = vel_out_ff;
      time_out_in = time_out_ff;

      if (csr_write) begin
         case (csr_index)
            REG_RELEASE_COEF: release_coef_in = pwdata[COEF_BITS-1:0];
            REG_ATTACK_COEF: attack_coef_in = pwdata[COEF_BITS-1:0];
            REG_ONSET_THRESHOLD: threshold_in = pwdata[LEVEL_BITS-1:0];
            REG_NOTE_NUMBER: note_number_in = pwdata[NOTE_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ax_in = follower_type'(FOLLOWER_BITS'(mag) << (FOLLOWER_BITS - SAMPLE_BITS));
               pos_in = req.frame_position;
               state_in = S_REL_MUL;
            end
         end
         S_REL_MUL: state_in = S_REL_ADD;
         S_REL_ADD: begin
            rel_in = (ax_ff > mix_out) ? ax_ff : mix_out;
            state_in = S_ATT_MUL;
         end
         S_ATT_MUL: state_in = S_ATT_ADD;
         S_ATT_ADD: begin
            att_in = mix_out;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               env_out_in = env;
               fire_out_in = fire;
               note_out_in = fire ? note_number_ff : '0;
               vel_out_in = fire ? vel : '0;
               time_out_in = fire ? pos_ff : '0;
               if (open_now) begin
                  if (ax15 > peak_ff) begin
                     peak_in = ax15;
                  end
               end else if (open_ff) begin
                  // window closed: restart the peak at the current magnitude
                  peak_in = ax15;
               end
               open_in = open_now;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         release_coef_ff <= RESET_RELEASE_COEF;
         attack_coef_ff <= RESET_ATTACK_COEF;
         threshold_ff <= RESET_ONSET_THRESHOLD;
         note_number_ff <= RESET_NOTE_NUMBER;
         rel_ff <= '0;
         att_ff <= '0;
         open_ff <= 1'b0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         release_coef_ff <= release_coef_in;
         attack_coef_ff <= attack_coef_in;
         threshold_ff <= threshold_in;
         note_number_ff <= note_number_in;
         rel_ff <= rel_in;
         att_ff <= att_in;
         open_ff <= open_in;
         peak_ff <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      pos_ff <= pos_in;
      prod_ff <= prod_in;
      env_out_ff <= env_out_in;
      fire_out_ff <= fire_out_in;
      note_out_ff <= note_out_in;
      vel_out_ff <= vel_out_in;
      time_out_ff <= time_out_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.envelope_level = env_out_ff;
   assign rsp.note_on_valid = fire_out_ff;
   assign rsp.note_out = note_out_ff;
   assign rsp.velocity = vel_out_ff;
   assign rsp.event_time = time_out_ff;

endmodule
